>>> src/clns_pkg.sv
`timescale 1ns / 1ps

package clns_pkg;

    // request kinds
    localparam logic [3:0] ACT_TEXT   = 4'd0;
    localparam logic [3:0] ACT_DATA   = 4'd1;
    localparam logic [3:0] ACT_CMD    = 4'd2;
    localparam logic [3:0] ACT_NIBBLE = 4'd3;
    localparam logic [3:0] ACT_CTRL   = 4'd4;
    localparam logic [3:0] ACT_SHIFT  = 4'd5;
    localparam logic [3:0] ACT_CURSOR = 4'd6;
    localparam logic [3:0] ACT_CLEAR  = 4'd7;
    localparam logic [3:0] ACT_INIT   = 4'd8;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_DISP_ON  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISP_OFF = 2'd1;

    // text control characters
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_FF = 8'h0C;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    // timing in microseconds
    localparam logic [15:0] T_POWER_UP   = 16'd40000;
    localparam logic [12:0] T_STROBE     = 13'd100;
    localparam logic [12:0] T_CMD_DONE   = 13'd200;
    localparam logic [12:0] T_CLEAR_DONE = 13'd2200;
    localparam logic [12:0] T_INIT_FIRST = 13'd5100;

    localparam logic [3:0] INIT_STROBES = 4'd14;

    typedef struct packed {
        logic       latch;   // capture request
        logic       load;    // load next strobe into output register
        logic       last;    // strobe being loaded ends the request
        logic [3:0] step;    // strobe number within the request
    } t_dp_cmd;

    typedef struct packed {
        logic [3:0] num_strobes;
    } t_dp_status;

endpackage

>>> src/char_lcd_nibble_sequencer_unit.sv
// channel   | direction | handshake              | beat payload
// ----------+-----------+------------------------+---------------------------------------------
// request   | in        | i_valid / o_ready      | i_action, i_value
// strobe    | out       | o_valid / i_ready      | o_rs, o_nibble, o_wait_before_us,
//           |           |                        | o_wait_after_us, o_last
// config    | in        | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// a request with N strobes (1, 2 or 14) sends one strobe per cycle while the output is not stalled,
// set by the single output register the strobe stepper loads
// an unused request kind sends nothing and goes back to idle
// the last strobe sits in the output register while the next request is taken
// reset is synchronous, active low, and leaves the display flags at on=4, off=0
// a stalled output beat freezes the stepper; config writes are always taken
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request beat
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [3:0]                        i_action,
    input  logic [7:0]                        i_value,
    // strobe beat
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_rs,
    output logic [3:0]                        o_nibble,
    output logic [15:0]                       o_wait_before_us,
    output logic [12:0]                       o_wait_after_us,
    output logic                              o_last,
    // register writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [clns_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [clns_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import clns_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // registers have no side effects, so writes never stall
    assign o_cfg_ready = 1'b1;

    // controller: request accept, strobe stepping, output valid
    clns_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_cmd    (dp_cmd),
        .i_status (dp_status)
    );

    // datapath: request capture, strobe decode, output register, flags
    clns_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_status         (dp_status),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_action         (i_action),
        .i_value          (i_value),
        .o_rs             (o_rs),
        .o_nibble         (o_nibble),
        .o_wait_before_us (o_wait_before_us),
        .o_wait_after_us  (o_wait_after_us),
        .o_last           (o_last)
    );

endmodule

>>> src/clns_ctrl.sv
`timescale 1ns / 1ps

module clns_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    output clns_pkg::t_dp_cmd   o_cmd,
    input  clns_pkg::t_dp_status i_status
);
    import clns_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic       r_state, n_state;
    logic [3:0] r_step, n_step;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == ST_IDLE);
    assign o_valid  = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        o_cmd       = '0;
        o_cmd.step  = r_step;
        o_cmd.latch = i_valid && (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.latch) begin
                    n_state = ST_RUN;
                    n_step  = '0;
                end
            end
            ST_RUN: begin
                if (out_free) begin
                    if (i_status.num_strobes == 4'd0) begin
                        // unused request kind, nothing to send
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.load = 1'b1;
                        o_cmd.last = (r_step == i_status.num_strobes - 4'd1);
                        n_step     = r_step + 4'd1;
                        if (o_cmd.last) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
        n_out_valid = o_cmd.load ? 1'b1 : (i_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> src/clns_dp.sv
`timescale 1ns / 1ps

module clns_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  clns_pkg::t_dp_cmd                 i_cmd,
    output clns_pkg::t_dp_status              o_status,
    input  logic                              i_cfg_we,
    input  logic [clns_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [clns_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [3:0]                        i_action,
    input  logic [7:0]                        i_value,
    output logic                              o_rs,
    output logic [3:0]                        o_nibble,
    output logic [15:0]                       o_wait_before_us,
    output logic [12:0]                       o_wait_after_us,
    output logic                              o_last
);
    import clns_pkg::*;

    logic [2:0]  r_on_flags;
    logic [2:0]  r_off_flags;
    logic [3:0]  r_action;
    logic [7:0]  r_value;

    logic [3:0]  r_nibble;
    logic        r_rs;
    logic [15:0] r_before;
    logic [12:0] r_after;
    logic        r_last;

    logic        s_rs;
    logic        s_cmd;
    logic        s_clear;
    logic        s_single;
    logic [7:0]  s_byte;
    logic [2:0]  init_idx;
    logic [3:0]  n_nibble;
    logic [15:0] n_before;
    logic [12:0] n_after;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_flags  <= 3'd4;
            r_off_flags <= 3'd0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_DISP_ON) begin
                r_on_flags <= i_cfg_data[2:0];
            end else if (i_cfg_index == CFG_DISP_OFF) begin
                r_off_flags <= i_cfg_data[2:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_action <= i_action;
            r_value  <= i_value;
        end
    end

    always_comb begin
        case (r_action)
            ACT_NIBBLE: o_status.num_strobes = 4'd1;
            ACT_INIT:   o_status.num_strobes = INIT_STROBES;
            default: begin
                if (r_action inside {[ACT_TEXT:ACT_CLEAR]}) begin
                    o_status.num_strobes = 4'd2;
                end else begin
                    o_status.num_strobes = 4'd0;
                end
            end
        endcase
    end

    // init: two lone nibbles, then one byte per strobe pair
    assign init_idx = i_cmd.step[3:1] - 3'd1;

    always_comb begin
        s_rs     = 1'b0;
        s_cmd    = 1'b1;
        s_clear  = 1'b0;
        s_single = 1'b0;
        s_byte   = r_value;
        case (r_action)
            ACT_TEXT: begin
                if (r_value == CHAR_CR) begin
                    s_byte = 8'h80;
                end else if (r_value == CHAR_LF) begin
                    s_byte = 8'hC0;
                end else if (r_value == CHAR_FF) begin
                    s_byte  = 8'h01;
                    s_clear = 1'b1;
                end else begin
                    s_rs  = 1'b1;
                    s_cmd = 1'b0;
                end
            end
            ACT_DATA: begin
                s_rs  = 1'b1;
                s_cmd = 1'b0;
            end
            ACT_CMD:    s_byte = r_value;
            ACT_NIBBLE: s_single = 1'b1;
            ACT_CTRL:   s_byte = {5'b00001, r_value[2:0]};
            ACT_SHIFT:  s_byte = {5'b00011, r_value[0], 2'b00};
            ACT_CURSOR: s_byte = {1'b1, r_value[6:0]};
            ACT_CLEAR: begin
                s_byte  = 8'h01;
                s_clear = 1'b1;
            end
            ACT_INIT: begin
                case (init_idx)
                    3'd0:    s_byte = 8'h32;
                    3'd1:    s_byte = 8'h28;
                    3'd2:    s_byte = {5'b00001, r_off_flags};
                    3'd3: begin
                        s_byte  = 8'h01;
                        s_clear = 1'b1;
                    end
                    3'd4:    s_byte = 8'h06;
                    3'd5:    s_byte = {5'b00001, r_on_flags};
                    default: s_byte = 8'h00;
                endcase
            end
            default: s_byte = r_value;
        endcase
    end

    always_comb begin
        n_before = '0;
        if (s_single) begin
            n_nibble = r_value[3:0];
            n_after  = T_STROBE;
        end else if (r_action == ACT_INIT && i_cmd.step < 4'd2) begin
            // wake-up nibbles
            n_nibble = 4'h3;
            if (i_cmd.step == 4'd0) begin
                n_before = T_POWER_UP;
                n_after  = T_INIT_FIRST;
            end else begin
                n_after  = T_STROBE;
            end
        end else if (!i_cmd.step[0]) begin
            n_nibble = s_byte[7:4];
            n_after  = T_STROBE;
        end else begin
            n_nibble = s_byte[3:0];
            if (s_clear) begin
                n_after = T_CLEAR_DONE;
            end else if (s_cmd) begin
                n_after = T_CMD_DONE;
            end else begin
                n_after = T_STROBE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rs     <= s_rs;
            r_nibble <= n_nibble;
            r_before <= n_before;
            r_after  <= n_after;
            r_last   <= i_cmd.last;
        end
    end

    assign o_rs             = r_rs;
    assign o_nibble         = r_nibble;
    assign o_wait_before_us = r_before;
    assign o_wait_after_us  = r_after;
    assign o_last           = r_last;

endmodule

>>> src/clns_checker.sv
`timescale 1ns / 1ps

module clns_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_ready,
    input logic                              o_valid,
    input logic                              i_ready,
    input logic                              o_rs,
    input logic [3:0]                        o_nibble,
    input logic [15:0]                       o_wait_before_us,
    input logic                              o_last
);
    import clns_pkg::*;

    // stalled strobe holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_nibble) && $stable(o_last))
        else $error("stalled strobe changed");

    // taking a request always makes the unit go busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request taken without going busy");

    // no new request before the last strobe of the current one
    a_no_accept_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> !o_ready)
        else $error("ready while a request is partly sent");

    // strobes of one request follow back to back
    a_next_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last && i_ready |=> o_valid)
        else $error("gap inside a request");

    // only the power-up strobe waits before, and it is a command nibble 3
    a_power_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_wait_before_us != 16'd0) |-> (o_nibble == 4'h3) && !o_rs && !o_last)
        else $error("unexpected wait before strobe");

endmodule

bind char_lcd_nibble_sequencer_unit clns_checker u_clns_checker (.*);
